// ===== hw/rtl/jss_pkg.sv =====
// shared types and constants for the jacobi stencil sweep block
package jss_pkg;

   localparam int MAX_WIDTH_DEF     = 1024;
   localparam int FIFO_DEPTH_DEF    = 8;
   localparam int MAX_HEIGHT        = 4096;
   localparam int MIN_GRID          = 3;

   localparam int SAMPLE_W          = 32;
   localparam int ROW_W             = 12;
   localparam int COL_W             = 10;
   localparam int RES_W             = 64;
   localparam int GRID_WIDTH_W      = 11;
   localparam int GRID_HEIGHT_W     = 13;
   localparam int CSR_ADDR_W        = 2;
   localparam int CSR_DATA_W        = 16;
   localparam int RSP_DATA_W        = 120;
   localparam int PAD_W             = RSP_DATA_W - (RES_W + COL_W + ROW_W + SAMPLE_W);

   localparam int RESET_GRID_WIDTH  = 8;
   localparam int RESET_GRID_HEIGHT = 8;

   localparam logic [SAMPLE_W-1:0] SIGN_FLIP = 32'h8000_0000;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_GRID_WIDTH  = 2'd0,
      CSR_GRID_HEIGHT = 2'd1
   } csr_index_type;

   // one result transaction on its way to the output
   typedef struct packed {
      logic                last;
      logic [RES_W-1:0]    residual;
      logic [COL_W-1:0]    col_index;
      logic [ROW_W-1:0]    row_index;
      logic [SAMPLE_W-1:0] new_value;
   } result_type;

   // per-stage control flags
   typedef struct packed {
      logic valid;
      logic interior;
      logic tile_end;
   } ctl_type;

endpackage

// ===== hw/rtl/jss_fifo.sv =====
// result queue between the stencil pipeline and the output channel
module jss_fifo #(
   parameter int DEPTH = jss_pkg::FIFO_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  jss_pkg::result_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output jss_pkg::result_type pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   jss_pkg::result_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;
   logic          pop;

   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/jacobi_stencil_sweep.sv =====
// Jacobi 5-point stencil sweep: one sample accepted per clock, sustained, whenever
// the result queue has room. Two line memories (one row each, MAX_WIDTH entries,
// registered reads, two read ports each) hold the previous rows; the sample stream
// itself supplies the bottom neighbor. An interior point's result passes through
// the average, magnitude, square and accumulate stages once the sample below it is
// accepted, then waits in a FIFO_DEPTH-entry queue; req_tready drops only when that
// many results are in flight or waiting. The squared-change sum (saturating Q32.32)
// and the row and column counters clear after the last sample of each tile. Line
// memories are not cleared at reset, so no start-up pass is needed.
module jacobi_stencil_sweep #(
   parameter int MAX_WIDTH  = jss_pkg::MAX_WIDTH_DEF,
   parameter int FIFO_DEPTH = jss_pkg::FIFO_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [jss_pkg::SAMPLE_W-1:0]       req_tdata,   // sample
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [jss_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // new_value, row_index,
                                                           // col_index, residual, pad
   output logic                               rsp_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [jss_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [jss_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int NW = $clog2(FIFO_DEPTH + 1);
   localparam int SW = jss_pkg::SAMPLE_W;
   localparam int HW = jss_pkg::GRID_HEIGHT_W;

   // configuration
   logic [jss_pkg::GRID_WIDTH_W-1:0]  grid_width_ff, grid_width_in;
   logic [jss_pkg::GRID_HEIGHT_W-1:0] grid_height_ff, grid_height_in;
   logic [WW-1:0] w_eff;
   logic [HW-1:0] h_eff;

   // position and bookkeeping
   logic [CW-1:0]               col_ff, col_in;
   logic [jss_pkg::ROW_W-1:0]   row_ff, row_in;
   logic [jss_pkg::RES_W-1:0]   residual_ff, residual_in;
   logic [NW-1:0]               pending_ff, pending_in;

   // line memories and their read registers
   logic [SW-1:0] upper_mem  [MAX_WIDTH];
   logic [SW-1:0] middle_mem [MAX_WIDTH];
   logic [SW-1:0] up_top_rd_ff, up_left_rd_ff, mid_center_rd_ff, mid_right_rd_ff;

   // accept stage
   logic          accept;
   logic [CW-1:0] addr_c, addr_l, addr_r;
   logic          interior0, last0, col_wrap, row_wrap;
   logic [WW:0]   col_ext;
   jss_pkg::ctl_type    ctl0;
   jss_pkg::result_type pay0;

   // stage 1: memory data ready
   jss_pkg::ctl_type    st1_ctl_ff;
   jss_pkg::result_type st1_pay_ff;
   logic [CW-1:0]       st1_col_ff;
   logic [SW-1:0]       st1_sample_ff;
   logic                fwd_top_ff, fwd_left_ff, fwd_top_in, fwd_left_in;
   logic [SW-1:0]       fwd_data_ff;
   logic [SW-1:0]       left_c, top_c;
   logic [SW+1:0]       sum_c;
   logic [SW-1:0]       st2_q_in;

   // stage 2: rounded average
   jss_pkg::ctl_type    st2_ctl_ff;
   jss_pkg::result_type st2_pay_ff, st2_pay_in;
   logic [SW-1:0]       st2_q_ff, st2_bc_ff;
   logic [SW-1:0]       st3_mag_in;

   // stage 3: change magnitude
   jss_pkg::ctl_type    st3_ctl_ff;
   jss_pkg::result_type st3_pay_ff;
   logic [SW-1:0]       st3_mag_ff;
   logic [2*SW-1:0]     st4_sq_in;

   // stage 4: squared change, accumulate
   jss_pkg::ctl_type    st4_ctl_ff;
   jss_pkg::result_type st4_pay_ff;
   logic [2*SW-1:0]     st4_sq_ff;
   logic [jss_pkg::RES_W:0] acc_c;
   logic [jss_pkg::RES_W-1:0] res_new;

   logic                push_valid;
   jss_pkg::result_type push_data, pop_data;
   logic                pop;

   // ---------------- configuration ----------------
   assign csr_ready = !reset;

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      if (csr_valid && csr_ready) begin
         case (jss_pkg::csr_index_type'(csr_addr))
            jss_pkg::CSR_GRID_WIDTH: begin
               grid_width_in = csr_wdata[jss_pkg::GRID_WIDTH_W-1:0];
            end
            jss_pkg::CSR_GRID_HEIGHT: begin
               grid_height_in = csr_wdata[jss_pkg::GRID_HEIGHT_W-1:0];
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      if (32'(grid_width_ff) < 32'(jss_pkg::MIN_GRID)) begin
         w_eff = WW'(jss_pkg::MIN_GRID);
      end else if (32'(grid_width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(grid_width_ff);
      end
      if (32'(grid_height_ff) < 32'(jss_pkg::MIN_GRID)) begin
         h_eff = HW'(jss_pkg::MIN_GRID);
      end else if (32'(grid_height_ff) > 32'(jss_pkg::MAX_HEIGHT)) begin
         h_eff = HW'(jss_pkg::MAX_HEIGHT);
      end else begin
         h_eff = grid_height_ff;
      end
   end

   // ---------------- accept stage ----------------
   assign req_tready = !reset && (32'(pending_ff) < 32'(FIFO_DEPTH));
   assign accept     = req_tvalid && req_tready;

   assign addr_c  = col_ff;
   assign addr_l  = (col_ff == '0) ? CW'(MAX_WIDTH - 1) : col_ff - 1'b1;
   assign addr_r  = (col_ff == CW'(MAX_WIDTH - 1)) ? '0 : col_ff + 1'b1;
   assign col_ext = (WW + 1)'(col_ff);

   assign interior0 = (row_ff >= jss_pkg::ROW_W'(2)) && (col_ff != '0) &&
                      (col_ext + (WW + 1)'(2) <= (WW + 1)'(w_eff));
   assign last0     = ((HW'(row_ff) + HW'(1)) == h_eff) &&
                      ((col_ext + (WW + 1)'(2)) == (WW + 1)'(w_eff));
   assign col_wrap  = (col_ext + (WW + 1)'(1)) >= (WW + 1)'(w_eff);
   assign row_wrap  = (HW'(row_ff) + HW'(1)) >= h_eff;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_comb begin
      ctl0.valid     = accept;
      ctl0.interior  = interior0;
      ctl0.tile_end  = col_wrap && row_wrap;
      pay0           = '0;
      pay0.last      = last0;
      pay0.row_index = row_ff - 1'b1;
      pay0.col_index = jss_pkg::COL_W'(col_ff);
   end

   // the stage-1 item writes upper[st1_col] on the same edge as these reads
   assign fwd_top_in  = st1_ctl_ff.valid && (st1_col_ff == addr_c);
   assign fwd_left_in = st1_ctl_ff.valid && (st1_col_ff == addr_l);

   always_ff @(posedge clock) begin
      up_top_rd_ff     <= upper_mem[addr_c];
      up_left_rd_ff    <= upper_mem[addr_l];
      mid_center_rd_ff <= middle_mem[addr_c];
      mid_right_rd_ff  <= middle_mem[addr_r];
      if (accept) begin
         middle_mem[addr_c] <= req_tdata;
      end
      if (st1_ctl_ff.valid) begin
         upper_mem[st1_col_ff] <= mid_center_rd_ff;
      end
   end

   // ---------------- stage 1: average ----------------
   assign left_c = fwd_left_ff ? fwd_data_ff : up_left_rd_ff;
   assign top_c  = fwd_top_ff  ? fwd_data_ff : up_top_rd_ff;

   // offset-binary sum keeps the rounding shift unsigned
   assign sum_c    = (SW + 2)'(left_c ^ jss_pkg::SIGN_FLIP) +
                     (SW + 2)'(top_c ^ jss_pkg::SIGN_FLIP) +
                     (SW + 2)'(mid_right_rd_ff ^ jss_pkg::SIGN_FLIP) +
                     (SW + 2)'(st1_sample_ff ^ jss_pkg::SIGN_FLIP) +
                     (SW + 2)'(2);
   assign st2_q_in = sum_c[SW+1:2];

   always_comb begin
      st2_pay_in           = st1_pay_ff;
      st2_pay_in.new_value = st2_q_in ^ jss_pkg::SIGN_FLIP;
   end

   // ---------------- stage 2: magnitude ----------------
   assign st3_mag_in = (st2_q_ff >= st2_bc_ff) ? st2_q_ff - st2_bc_ff : st2_bc_ff - st2_q_ff;

   // ---------------- stage 3: square ----------------
   assign st4_sq_in = st3_mag_ff * st3_mag_ff;

   // ---------------- stage 4: saturating accumulate ----------------
   assign acc_c   = (jss_pkg::RES_W + 1)'(residual_ff) + (jss_pkg::RES_W + 1)'(st4_sq_ff);
   assign res_new = acc_c[jss_pkg::RES_W] ? '1 : acc_c[jss_pkg::RES_W-1:0];

   always_comb begin
      residual_in = residual_ff;
      if (st4_ctl_ff.valid) begin
         if (st4_ctl_ff.tile_end) begin
            residual_in = '0;
         end else if (st4_ctl_ff.interior) begin
            residual_in = res_new;
         end
      end
   end

   assign push_valid = st4_ctl_ff.valid && st4_ctl_ff.interior;

   always_comb begin
      push_data          = st4_pay_ff;
      push_data.residual = res_new;
   end

   // results accepted but not yet taken on rsp
   assign pop = rsp_tvalid && rsp_tready;

   always_comb begin
      pending_in = pending_ff;
      if (accept && interior0 && !pop) begin
         pending_in = pending_ff + 1'b1;
      end else if (pop && !(accept && interior0)) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= jss_pkg::GRID_WIDTH_W'(jss_pkg::RESET_GRID_WIDTH);
         grid_height_ff <= jss_pkg::GRID_HEIGHT_W'(jss_pkg::RESET_GRID_HEIGHT);
         col_ff         <= '0;
         row_ff         <= '0;
         residual_ff    <= '0;
         pending_ff     <= '0;
         st1_ctl_ff     <= '0;
         st2_ctl_ff     <= '0;
         st3_ctl_ff     <= '0;
         st4_ctl_ff     <= '0;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         residual_ff    <= residual_in;
         pending_ff     <= pending_in;
         st1_ctl_ff     <= ctl0;
         st2_ctl_ff     <= st1_ctl_ff;
         st3_ctl_ff     <= st2_ctl_ff;
         st4_ctl_ff     <= st3_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      st1_pay_ff    <= pay0;
      st1_col_ff    <= addr_c;
      st1_sample_ff <= req_tdata;
      fwd_top_ff    <= fwd_top_in;
      fwd_left_ff   <= fwd_left_in;
      fwd_data_ff   <= mid_center_rd_ff;
      st2_pay_ff    <= st2_pay_in;
      st2_q_ff      <= st2_q_in;
      st2_bc_ff     <= mid_center_rd_ff ^ jss_pkg::SIGN_FLIP;
      st3_pay_ff    <= st2_pay_ff;
      st3_mag_ff    <= st3_mag_in;
      st4_pay_ff    <= st3_pay_ff;
      st4_sq_ff     <= st4_sq_in;
   end

   // ---------------- output queue ----------------
   jss_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop_valid  (rsp_tvalid),
      .pop_ready  (rsp_tready),
      .pop_data   (pop_data)
   );

   assign rsp_tdata = {{jss_pkg::PAD_W{1'b0}}, pop_data.residual, pop_data.col_index,
                       pop_data.row_index, pop_data.new_value};
   assign rsp_tlast = pop_data.last;

   // ---------------- assertions ----------------
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      32'(pending_ff) <= 32'(FIFO_DEPTH))
      else $error("pending result count exceeds queue depth");

   a_pending_inc: assert property (@(posedge clock) disable iff (reset)
      (accept && interior0 && !pop) |=> (pending_ff == $past(pending_ff) + 1'b1))
      else $error("interior transaction not counted as pending");

   a_tile_clear: assert property (@(posedge clock) disable iff (reset)
      (st4_ctl_ff.valid && st4_ctl_ff.tile_end) |=> (residual_ff == '0))
      else $error("residual sum not cleared at tile end");

   a_fwd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({fwd_top_ff, fwd_left_ff}))
      else $error("both upper line forwards selected");

endmodule

// ===== sim/tb_jacobi_stencil_sweep.sv =====
// self-checking testbench for the jacobi stencil sweep block
`timescale 1ns / 100ps

module tb_jacobi_stencil_sweep;

   localparam int MAX_W         = jss_pkg::MAX_WIDTH_DEF;
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_ITEMS  = 330;
   localparam int ROW_LSB       = jss_pkg::SAMPLE_W;
   localparam int COL_LSB       = ROW_LSB + jss_pkg::ROW_W;
   localparam int RES_LSB       = COL_LSB + jss_pkg::COL_W;
   localparam int PAD_LSB       = RES_LSB + jss_pkg::RES_W;
   localparam logic [jss_pkg::CSR_ADDR_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam logic [jss_pkg::SAMPLE_W-1:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [jss_pkg::SAMPLE_W-1:0] Q_MIN = 32'h8000_0000;

   logic                             clock;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [jss_pkg::SAMPLE_W-1:0]     req_tdata  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [jss_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                             rsp_tlast;
   logic                             csr_valid  = 1'b0;
   logic                             csr_ready;
   logic [jss_pkg::CSR_ADDR_W-1:0]   csr_addr   = '0;
   logic [jss_pkg::CSR_DATA_W-1:0]   csr_wdata  = '0;

   // samples waiting to be sent and interior updates waiting to come back
   logic [jss_pkg::SAMPLE_W-1:0] pending_samples[$];
   jss_pkg::result_type          expected_updates[$];
   int                           fail_count = 0;

   // shadow of the sweep state
   logic [jss_pkg::SAMPLE_W-1:0]      upper_row [MAX_W];
   logic [jss_pkg::SAMPLE_W-1:0]      middle_row[MAX_W];
   int unsigned                       row_ctr = 0;
   int unsigned                       col_ctr = 0;
   logic [jss_pkg::RES_W-1:0]         residual_acc = '0;
   logic [jss_pkg::GRID_WIDTH_W-1:0]  width_reg  =
      jss_pkg::GRID_WIDTH_W'(jss_pkg::RESET_GRID_WIDTH);
   logic [jss_pkg::GRID_HEIGHT_W-1:0] height_reg =
      jss_pkg::GRID_HEIGHT_W'(jss_pkg::RESET_GRID_HEIGHT);

   int burst_left = 0;
   int gap_left   = 0;
   int stall_left = 0;
   int stall_mode = 0;

   jacobi_stencil_sweep dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned eff_width();
      int unsigned w;
      w = 32'(width_reg);
      if (w < jss_pkg::MIN_GRID) w = jss_pkg::MIN_GRID;
      if (w > MAX_W) w = MAX_W;
      return w;
   endfunction

   function automatic int unsigned eff_height();
      int unsigned h;
      h = 32'(height_reg);
      if (h < jss_pkg::MIN_GRID) h = jss_pkg::MIN_GRID;
      if (h > jss_pkg::MAX_HEIGHT) h = jss_pkg::MAX_HEIGHT;
      return h;
   endfunction

   // offset binary: value + 2^31, never negative
   function automatic logic [63:0] biased(logic [jss_pkg::SAMPLE_W-1:0] v);
      return {32'd0, v ^ jss_pkg::SIGN_FLIP};
   endfunction

   // samples needed to reach the end of the current tile
   function automatic int unsigned tile_remaining();
      int unsigned w, h, cols_left, rows_after;
      w = eff_width();
      h = eff_height();
      cols_left  = (col_ctr + 1 >= w) ? 1 : w - col_ctr;
      rows_after = (row_ctr + 1 >= h) ? 0 : h - 1 - row_ctr;
      return cols_left + rows_after * w;
   endfunction

   // advance the shadow sweep by one sample, queueing the update it produces
   task automatic predict_update(input logic [jss_pkg::SAMPLE_W-1:0] s);
      int unsigned w, h, r, c;
      logic [63:0] sum, q, bc, mag, sq;
      logic [64:0] acc;
      jss_pkg::result_type upd;
      w = eff_width();
      h = eff_height();
      r = row_ctr;
      c = col_ctr % MAX_W;
      if (r >= 2 && c >= 1 && c + 2 <= w) begin
         // left comes from the upper row already shifted in this pass
         sum = biased(upper_row[c-1]) + biased(middle_row[(c+1) % MAX_W])
             + biased(upper_row[c]) + biased(s);
         q   = (sum + 64'd2) >> 2;
         bc  = biased(middle_row[c]);
         mag = (q >= bc) ? q - bc : bc - q;
         sq  = mag * mag;
         acc = {1'b0, residual_acc} + {1'b0, sq};
         residual_acc = acc[64] ? '1 : acc[63:0];
         upd.new_value = q[jss_pkg::SAMPLE_W-1:0] ^ jss_pkg::SIGN_FLIP;
         upd.row_index = jss_pkg::ROW_W'(r - 1);
         upd.col_index = jss_pkg::COL_W'(c);
         upd.residual  = residual_acc;
         upd.last      = (r + 1 == h) && (c + 2 == w);
         expected_updates.push_back(upd);
      end
      upper_row[c]  = middle_row[c];
      middle_row[c] = s;
      if (col_ctr + 1 >= w) begin
         col_ctr = 0;
         if (row_ctr + 1 >= h) begin
            row_ctr      = 0;
            residual_acc = '0;
         end else begin
            row_ctr++;
         end
      end else begin
         col_ctr++;
      end
   endtask

   function automatic logic [jss_pkg::SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return Q_MAX;
         1:       return Q_MIN;
         2, 3:    return $urandom_range(0, 8) - 4;   // tiny values hit rounding ties
         default: return $urandom();
      endcase
   endfunction

   function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", field, want, got);
         fail_count++;
      end
   endfunction

   // sample driver: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_update(req_tdata);
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_samples.pop_front();
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 40);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor with its own back-pressure pattern
   always @(posedge clock) begin
      jss_pkg::result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_updates.size() == 0) begin
               $error("unexpected result transaction: tdata %0h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_updates.pop_front();
               check_field("new_value", 64'(want.new_value),
                           64'(rsp_tdata[jss_pkg::SAMPLE_W-1:0]));
               check_field("row_index", 64'(want.row_index),
                           64'(rsp_tdata[ROW_LSB +: jss_pkg::ROW_W]));
               check_field("col_index", 64'(want.col_index),
                           64'(rsp_tdata[COL_LSB +: jss_pkg::COL_W]));
               check_field("residual", want.residual, rsp_tdata[RES_LSB +: jss_pkg::RES_W]);
               check_field("pad", 64'd0, 64'(rsp_tdata[PAD_LSB +: jss_pkg::PAD_W]));
               check_field("last", 64'(want.last), 64'(rsp_tlast));
            end
         end
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(8, 200);
         end else begin
            stall_left--;
         end
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   task automatic write_csr(input logic [jss_pkg::CSR_ADDR_W-1:0] idx,
                            input logic [jss_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         jss_pkg::CSR_GRID_WIDTH:  width_reg  = data[jss_pkg::GRID_WIDTH_W-1:0];
         jss_pkg::CSR_GRID_HEIGHT: height_reg = data[jss_pkg::GRID_HEIGHT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic queue_samples(input int unsigned count);
      @(negedge clock);
      repeat (count) pending_samples.push_back(pick_sample());
   endtask

   // block idle: everything sent, every update back, pipeline drained
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_tvalid || expected_updates.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [jss_pkg::SAMPLE_W-1:0] pattern[$];
      int unsigned random_count, w_cap, raw_w, raw_h, count;
      foreach (upper_row[i]) begin
         upper_row[i]  = '0;
         middle_row[i] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // 3x3 tile, halo at max around a min center: largest change
      write_csr(jss_pkg::CSR_GRID_WIDTH, 16'hF803);
      write_csr(jss_pkg::CSR_GRID_HEIGHT, 16'hE003);
      write_csr(CSR_UNMAPPED, 16'hFFFF);
      pattern = '{Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX};
      @(negedge clock);
      foreach (pattern[i]) pending_samples.push_back(pattern[i]);
      wait_idle();

      // 4x3 tile, two full-scale changes push the residual into saturation
      write_csr(jss_pkg::CSR_GRID_WIDTH, 16'h0004);
      pattern = '{32'd0, Q_MAX, Q_MIN, 32'd0,
                  Q_MAX, Q_MIN, Q_MAX, Q_MIN,
                  32'd0, Q_MAX, Q_MIN, 32'd0};
      @(negedge clock);
      foreach (pattern[i]) pending_samples.push_back(pattern[i]);
      wait_idle();

      // width past the limit, then narrowed mid-row so the column counter wraps
      write_csr(jss_pkg::CSR_GRID_WIDTH, 16'hFFFF);
      write_csr(jss_pkg::CSR_GRID_HEIGHT, 16'h0002);
      queue_samples(12);
      wait_idle();
      write_csr(jss_pkg::CSR_GRID_WIDTH, 16'h0008);
      queue_samples(tile_remaining());
      wait_idle();

      // tallest tile, cut short
      write_csr(jss_pkg::CSR_GRID_WIDTH, 16'h0003);
      write_csr(jss_pkg::CSR_GRID_HEIGHT, 16'h1000);
      queue_samples(30);
      wait_idle();

      // height past the limit, then cut short mid-tile so the row counter wraps
      write_csr(jss_pkg::CSR_GRID_HEIGHT, 16'h1FFF);
      queue_samples(30);
      wait_idle();
      write_csr(jss_pkg::CSR_GRID_HEIGHT, 16'h0004);
      queue_samples(tile_remaining() + eff_width() * eff_height());
      wait_idle();

      random_count = 0;
      while (random_count < RANDOM_ITEMS) begin
         // width may only grow at a tile start, so no unwritten line entry is read
         if (row_ctr == 0 && col_ctr == 0) begin
            w_cap = ($urandom_range(0, 5) == 0) ? 24 : 10;
         end else begin
            w_cap = eff_width();
         end
         raw_w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
                                             : $urandom_range(jss_pkg::MIN_GRID, w_cap);
         raw_h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
                                             : $urandom_range(jss_pkg::MIN_GRID, 7);
         if ($urandom_range(0, 3) != 0) begin
            write_csr(jss_pkg::CSR_GRID_WIDTH,
                      {5'($urandom()), jss_pkg::GRID_WIDTH_W'(raw_w)});
         end
         if ($urandom_range(0, 3) != 0) begin
            write_csr(jss_pkg::CSR_GRID_HEIGHT,
                      {3'($urandom()), jss_pkg::GRID_HEIGHT_W'(raw_h)});
         end
         if ($urandom_range(0, 2) != 0) begin
            count = tile_remaining() + $urandom_range(0, 1) * eff_width() * eff_height();
         end else begin
            count = $urandom_range(1, tile_remaining());
         end
         queue_samples(count);
         random_count += count;
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/jss_pkg.sv
hw/rtl/jss_fifo.sv
hw/rtl/jacobi_stencil_sweep.sv
sim/tb_jacobi_stencil_sweep.sv
